>>> rtl/khr_pkg.sv
// ----------------------------------------------------------------------------
// khr_pkg
// Shared constants, keymap tables and sequencer states for the key matrix
// to HID boot report converter.
// ----------------------------------------------------------------------------
package khr_pkg;

	localparam int ROWS      = 8;
	localparam int COLS      = 8;
	localparam int KEYS      = ROWS * COLS;
	localparam int KEY_SLOTS = 6;
	localparam int OUT_SLOTS = 6;

	localparam int FN_ROW = 5;
	localparam int FN_COL = 4;
	localparam logic [5:0] FN_POS = 6'(FN_ROW * COLS + FN_COL);

	localparam logic [7:0] MOD_FIRST = 8'hE0;
	localparam logic [7:0] MOD_LAST  = 8'hE7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef logic [7:0] key_code_t;

	// normal layer, row-major
	localparam key_code_t BASE_MAP [KEYS] = '{
		8'h1F, 8'h14, 8'h1A, 8'h16, 8'h04, 8'h1D, 8'h1B, 8'h06,
		8'h20, 8'h21, 8'h15, 8'h08, 8'h07, 8'h09, 8'h19, 8'h05,
		8'h22, 8'h23, 8'h1C, 8'h17, 8'h0A, 8'h0B, 8'h11, 8'h00,
		8'h1E, 8'h29, 8'h2B, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'h2C,
		8'h24, 8'h25, 8'h18, 8'h0C, 8'h0E, 8'h0D, 8'h10, 8'h00,
		8'h31, 8'h35, 8'h2A, 8'h28, 8'h00, 8'hE5, 8'hE6, 8'hE7,
		8'h26, 8'h27, 8'h12, 8'h13, 8'h33, 8'h0F, 8'h36, 8'h00,
		8'h2D, 8'h2E, 8'h30, 8'h2F, 8'h34, 8'h38, 8'h37, 8'h00
	};

	// fn layer, zero falls back to the normal layer
	localparam key_code_t ALT_MAP [KEYS] = '{
		8'h3B, 8'h00, 8'h00, 8'h80, 8'h81, 8'h00, 8'h00, 8'h00,
		8'h3C, 8'h3D, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00,
		8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h3A, 8'h66, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h40, 8'h41, 8'h00, 8'h46, 8'h4A, 8'h00, 8'h00, 8'h00,
		8'h49, 8'h4C, 8'h2A, 8'h28, 8'h00, 8'h00, 8'h00, 8'h78,
		8'h42, 8'h43, 8'h47, 8'h48, 8'h50, 8'h4B, 8'h4D, 8'h00,
		8'h44, 8'h45, 8'h00, 8'h52, 8'h4F, 8'h51, 8'h4E, 8'h00
	};

endpackage

>>> rtl/key_matrix_to_hid_report.sv
// ----------------------------------------------------------------------------
// key_matrix_to_hid_report
// Walks one 8x8 matrix scan key by key and builds a 6-key HID boot report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: scan_bits with in_valid / in_stall. A request is taken at
//   a rising edge with in_valid high and in_stall low. in_stall stays high
//   while a scan is being walked.
//   Output channel: modifier_bits and slot_zero..slot_five with out_valid /
//   out_stall, held in an output register until the receiver takes it.
//   Timing: after a request is taken, a position counter steps through all
//   64 keys, one key lookup per cycle, then the finish step loads the report
//   into the output register. The block stalls new scans during the walk and
//   the finish step and takes the next one once it is back in idle.
//   If the previous report is still stalled at the output when a walk
//   ends, the block waits in its finish step until the register frees up.
//   The next scan can be taken while a report waits in the output register.
//   Reset: previous scan and the per-key fn latches clear to zero, the
//   output register is empty and the block is ready for a request.
// ----------------------------------------------------------------------------
module key_matrix_to_hid_report (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] scan_bits,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [7:0]  modifier_bits,
	output logic [7:0]  slot_zero,
	output logic [7:0]  slot_one,
	output logic [7:0]  slot_two,
	output logic [7:0]  slot_three,
	output logic [7:0]  slot_four,
	output logic [7:0]  slot_five,
	output logic        out_valid,
	input  logic        out_stall
);

	khr_pkg::state_t state_q, state_d;

	logic [63:0] scan_q;
	logic [63:0] prev_q;
	logic [63:0] latch_q;
	logic [5:0]  pos_q;
	logic [2:0]  filled_q;
	logic [7:0]  mods_q;
	khr_pkg::key_code_t slots_q [khr_pkg::OUT_SLOTS];
	khr_pkg::key_code_t out_slots_q [khr_pkg::OUT_SLOTS];
	logic [7:0]  out_mods_q;
	logic        out_valid_q;

	logic       in_take;
	logic       out_free;
	logic       load_out;
	logic       last_pos;
	logic [7:0] row_now;
	logic [7:0] row_old;
	logic       visit;
	logic       pressed;
	logic       fn_down;
	logic       latch_new;
	khr_pkg::key_code_t base_code;
	khr_pkg::key_code_t alt_code;
	khr_pkg::key_code_t code;
	logic       is_mod;
	logic       slot_wr;

	assign out_free = !out_valid_q || !out_stall;
	assign last_pos = (pos_q == 6'(khr_pkg::KEYS - 1));

	// per-key datapath for the current walk position
	always_comb begin
		row_now   = scan_q[{pos_q[5:3], 3'b000} +: 8];
		row_old   = prev_q[{pos_q[5:3], 3'b000} +: 8];
		// quiet rows and anything after the slots fill are not visited
		visit     = ((row_now != 8'h00) || (row_old != 8'h00))
		            && (filled_q < 3'(khr_pkg::KEY_SLOTS));
		pressed   = scan_q[pos_q];
		fn_down   = scan_q[khr_pkg::FN_POS];
		latch_new = fn_down ? pressed : latch_q[pos_q];
		base_code = khr_pkg::BASE_MAP[pos_q];
		alt_code  = khr_pkg::ALT_MAP[pos_q];
		code      = (latch_new && (alt_code != 8'h00)) ? alt_code : base_code;
		is_mod    = code inside {[khr_pkg::MOD_FIRST:khr_pkg::MOD_LAST]};
		slot_wr   = visit && pressed && !is_mod && (code != 8'h00);
	end

	always_comb begin
		state_d  = state_q;
		in_take  = 1'b0;
		load_out = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			khr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					in_take = 1'b1;
					state_d = khr_pkg::ST_WALK;
				end
			end
			khr_pkg::ST_WALK: begin
				if (last_pos) begin
					state_d = khr_pkg::ST_FINISH;
				end
			end
			khr_pkg::ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = khr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = khr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= khr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk control and report accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= '0;
			mods_q   <= '0;
			prev_q   <= '0;
			latch_q  <= '0;
		end else begin
			if (in_take) begin
				pos_q    <= '0;
				filled_q <= '0;
				mods_q   <= '0;
			end else if (state_q == khr_pkg::ST_WALK) begin
				pos_q <= pos_q + 6'd1;
				if (visit) begin
					latch_q[pos_q] <= latch_new;
					if (pressed && is_mod) begin
						mods_q[code[2:0]] <= 1'b1;
					end
					if (slot_wr) begin
						filled_q <= filled_q + 3'd1;
					end
				end
			end
			if (load_out) begin
				prev_q <= scan_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			scan_q <= scan_bits;
			for (int k = 0; k < khr_pkg::OUT_SLOTS; k++) begin
				slots_q[k] <= 8'h00;
			end
		end else if ((state_q == khr_pkg::ST_WALK) && slot_wr) begin
			for (int k = 0; k < khr_pkg::OUT_SLOTS; k++) begin
				if (filled_q == 3'(k)) begin
					slots_q[k] <= code;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_mods_q <= mods_q;
			for (int k = 0; k < khr_pkg::OUT_SLOTS; k++) begin
				out_slots_q[k] <= slots_q[k];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign modifier_bits = out_mods_q;
	assign slot_zero     = out_slots_q[0];
	assign slot_one      = out_slots_q[1];
	assign slot_two      = out_slots_q[2];
	assign slot_three    = out_slots_q[3];
	assign slot_four     = out_slots_q[4];
	assign slot_five     = out_slots_q[5];

endmodule

>>> dv/hid_report_tb_pkg.sv
// ----------------------------------------------------------------------------
// hid_report_tb_pkg
// Report type, keymap tables and scoreboard class for the key matrix to HID
// boot report testbench. The scoreboard builds the expected report of each
// accepted scan request and checks the reports that leave the block.
// ----------------------------------------------------------------------------
package hid_report_tb_pkg;

	import khr_pkg::*;

	typedef struct packed {
		logic [7:0]      modifier;
		logic [5:0][7:0] slot;
	} hid_report_t;

	// normal layer, row-major
	localparam logic [7:0] PLAIN_CODES [64] = '{
		8'h1F, 8'h14, 8'h1A, 8'h16, 8'h04, 8'h1D, 8'h1B, 8'h06,
		8'h20, 8'h21, 8'h15, 8'h08, 8'h07, 8'h09, 8'h19, 8'h05,
		8'h22, 8'h23, 8'h1C, 8'h17, 8'h0A, 8'h0B, 8'h11, 8'h00,
		8'h1E, 8'h29, 8'h2B, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'h2C,
		8'h24, 8'h25, 8'h18, 8'h0C, 8'h0E, 8'h0D, 8'h10, 8'h00,
		8'h31, 8'h35, 8'h2A, 8'h28, 8'h00, 8'hE5, 8'hE6, 8'hE7,
		8'h26, 8'h27, 8'h12, 8'h13, 8'h33, 8'h0F, 8'h36, 8'h00,
		8'h2D, 8'h2E, 8'h30, 8'h2F, 8'h34, 8'h38, 8'h37, 8'h00
	};

	// fn layer, zero means use the normal layer
	localparam logic [7:0] FN_CODES [64] = '{
		8'h3B, 8'h00, 8'h00, 8'h80, 8'h81, 8'h00, 8'h00, 8'h00,
		8'h3C, 8'h3D, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00,
		8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h3A, 8'h66, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h40, 8'h41, 8'h00, 8'h46, 8'h4A, 8'h00, 8'h00, 8'h00,
		8'h49, 8'h4C, 8'h2A, 8'h28, 8'h00, 8'h00, 8'h00, 8'h78,
		8'h42, 8'h43, 8'h47, 8'h48, 8'h50, 8'h4B, 8'h4D, 8'h00,
		8'h44, 8'h45, 8'h00, 8'h52, 8'h4F, 8'h51, 8'h4E, 8'h00
	};

	class report_checker;

		logic [63:0] last_scan;
		logic [63:0] fn_held;
		hid_report_t pending_reports [$];
		int          mismatches;

		function new();
			last_scan  = '0;
			fn_held    = '0;
			mismatches = 0;
		endfunction

		function hid_report_t build_report(logic [63:0] scan);
			hid_report_t rep;
			logic        fn_down;
			logic [7:0]  code;
			int          filled;
			int          pos;
			rep     = '0;
			filled  = 0;
			fn_down = scan[FN_POS];
			for (int r = 0; r < 8; r++) begin
				// quiet row: nothing now, nothing last time
				if (scan[8*r +: 8] == 8'h00 && last_scan[8*r +: 8] == 8'h00)
					continue;
				for (int c = 0; c < 8 && filled < KEY_SLOTS; c++) begin
					pos = 8*r + c;
					if (fn_down)
						fn_held[pos] = scan[pos];
					if (!scan[pos])
						continue;
					if (fn_held[pos] && FN_CODES[pos] != 8'h00)
						code = FN_CODES[pos];
					else
						code = PLAIN_CODES[pos];
					if (code >= MOD_FIRST && code <= MOD_LAST) begin
						rep.modifier[code[2:0]] = 1'b1;
					end else if (code != 8'h00) begin
						rep.slot[filled] = code;
						filled++;
					end
				end
			end
			last_scan = scan;
			return rep;
		endfunction

		function void take_scan(logic [63:0] scan);
			pending_reports.push_back(build_report(scan));
		endfunction

		function void note_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %02h, got %02h", name, want, got);
			end
		endfunction

		function void check_report(hid_report_t got);
			hid_report_t want;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %h with no scan request waiting", got);
				return;
			end
			want = pending_reports.pop_front();
			note_field("modifier_bits", want.modifier, got.modifier);
			for (int k = 0; k < 6; k++)
				note_field($sformatf("slot %0d", k), want.slot[k], got.slot[k]);
		endfunction

		function int outstanding();
			return pending_reports.size();
		endfunction

	endclass

endpackage

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of key_matrix_to_hid_report: directed scans for fn latching,
// modifiers, unmapped keys, quiet rows and full slots, then random typing
// sequences and noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import khr_pkg::*;
	import hid_report_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic [63:0] scan_bits;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  modifier_bits;
	logic [7:0]  slot_zero;
	logic [7:0]  slot_one;
	logic [7:0]  slot_two;
	logic [7:0]  slot_three;
	logic [7:0]  slot_four;
	logic [7:0]  slot_five;
	logic        out_valid;
	logic        out_stall;

	report_checker board;
	bit            idle_on;

	key_matrix_to_hid_report dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_bits     (scan_bits),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.modifier_bits (modifier_bits),
		.slot_zero     (slot_zero),
		.slot_one      (slot_one),
		.slot_two      (slot_two),
		.slot_three    (slot_three),
		.slot_four     (slot_four),
		.slot_five     (slot_five),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic send_scan(input logic [63:0] scan);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		scan_bits = scan;
		in_valid  = 1'b1;
		do @(posedge clk); while (in_stall);
		board.take_scan(scan);
	endtask

	// hold off new requests until every report is out
	task automatic drain_reports();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
	endtask

	// report receiver
	initial begin
		int          hold;
		hid_report_t got;
		@(posedge arst_n);
		forever begin
			hold = idle_on ? $urandom_range(0, 4) : 0;
			@(negedge clk);
			out_stall = (hold > 0);
			if (hold > 0) begin
				repeat (hold - 1) @(negedge clk);
				@(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			got.modifier = modifier_bits;
			got.slot[0]  = slot_zero;
			got.slot[1]  = slot_one;
			got.slot[2]  = slot_two;
			got.slot[3]  = slot_three;
			got.slot[4]  = slot_four;
			got.slot[5]  = slot_five;
			board.check_report(got);
		end
	end

	initial begin
		logic [63:0] held;
		logic [63:0] scan;
		int          pick;
		board     = new();
		idle_on   = 1'b1;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		scan_bits = '0;
		out_stall = 1'b0;
		held      = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_scan(64'h0000_0000_0000_0000);
		send_scan(64'hFFFF_FFFF_FFFF_FFFF);
		send_scan(64'hFFFF_FFFF_FFFF_FFFF);
		send_scan(64'h0000_0000_0000_0001);
		send_scan(64'h8000_0000_0000_0000);
		// fn alone, then fn with a key, then the latched key on its own
		send_scan(64'h0000_1000_0000_0000);
		send_scan(64'h0000_1000_0000_0001);
		send_scan(64'h0000_0000_0000_0001);
		// fn held with the key released clears its latch
		send_scan(64'h0000_1000_0000_0000);
		send_scan(64'h0000_0000_0000_0001);
		send_scan(64'h0000_0000_0000_0000);
		send_scan(64'h0000_E000_7800_0000);
		// a latched modifier position turns into a plain key code
		send_scan(64'h0000_9000_0000_0000);
		send_scan(64'h0000_8000_0000_0000);
		send_scan(64'h0000_0000_0000_0000);
		send_scan(64'h0000_1000_0000_0000);
		send_scan(64'h8080_0080_0080_0000);
		// row 0 fills every slot, the modifiers later on are never reached
		send_scan(64'h0000_E000_7800_00FF);
		send_scan(64'h0000_1000_0000_FFFF);
		send_scan(64'h0000_0000_0000_FFFF);
		send_scan(64'hAAAA_AAAA_AAAA_AAAA);
		send_scan(64'h5555_5555_5555_5555);
		send_scan(64'h0000_0000_0000_0000);
		drain_reports();

		for (int i = 0; i < 730; i++) begin
			if (i % 150 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (i == 365)
				drain_reports();
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// typing: press or release a few keys, sometimes fn
				repeat ($urandom_range(1, 3)) begin
					pos_flip: held[$urandom_range(0, 63)] ^= 1'b1;
				end
				if ($urandom_range(0, 9) == 0)
					held[FN_POS] ^= 1'b1;
				if ($urandom_range(0, 19) == 0)
					held = '0;
				scan = held;
			end else if (pick < 85) begin
				scan = '0;
				repeat ($urandom_range(1, 8))
					scan[$urandom_range(0, 63)] = 1'b1;
				held = scan;
			end else if (pick < 95) begin
				scan = {$urandom(), $urandom()};
			end else begin
				scan = '0;
				held = '0;
			end
			send_scan(scan);
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
		repeat (80) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
